// ----- src/dialf_pkg.sv -----
`timescale 1ns / 1ps

package dialf_pkg;

    localparam int BYTE_W   = 8;
    localparam int TURNS_W  = 6;
    localparam int ANGLE_W  = 9;
    localparam int LEVEL_W  = 12;
    localparam int MAG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_COMPASS_TURNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_TURNS     = 1'd1;

    localparam logic [TURNS_W-1:0] TURNS_RESET = 6'd1;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [MAG_W-1:0] MAG_OVER  = 32'h8000_0001;
    localparam logic [MAG_W-1:0] LEVEL_MAX = 32'd4095;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_HEADER,
        PH_FIRST,
        PH_SECOND,
        PH_BAD
    } phase_t;

    typedef struct packed {
        logic sign;
        logic neg;
        logic digit;
    } field_flags_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] compass_level;
        logic [LEVEL_W-1:0] cue_level;
    } line_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- src/dialf_front.sv -----
`timescale 1ns / 1ps

module dialf_front
    import dialf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               push,
    output line_job_t          push_job
);

    phase_t        phase_reg, phase_next;
    logic [1:0]    hdr_reg, hdr_next;
    logic          trail_reg, trail_next;
    logic [MAG_W-1:0] mag1_reg, mag1_next;
    logic [MAG_W-1:0] mag2_reg, mag2_next;
    field_flags_t  fl1_reg, fl1_next;
    field_flags_t  fl2_reg, fl2_next;

    logic          is_space, is_digit, is_sign;
    logic          ok1, ok2;
    logic [1:0]    hp;
    logic [3:0]    digit_val;

    function automatic logic field_ok(field_flags_t f, logic [MAG_W-1:0] m);
        logic r;
        if (!f.digit)
            r = 1'b0;
        else if (f.neg)
            r = (m <= MAG_LIMIT);
        else
            r = (m <= MAG_LIMIT - 1);
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag_step(logic [MAG_W-1:0] m, logic [3:0] d);
        logic [MAG_W+2:0] w;
        logic [MAG_W-1:0] r;
        w = {m, 3'b000} + {2'b00, m, 1'b0} + {{(MAG_W-1){1'b0}}, d};
        if (m > MAG_LIMIT)
            r = m;
        else if (w > {3'b000, MAG_LIMIT})
            r = MAG_OVER;
        else
            r = w[MAG_W-1:0];
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] level(field_flags_t f, logic [MAG_W-1:0] m);
        logic [LEVEL_W-1:0] r;
        if (f.neg || m == '0)
            r = '0;
        else if (m > LEVEL_MAX)
            r = LEVEL_MAX[LEVEL_W-1:0];
        else
            r = m[LEVEL_W-1:0];
        return r;
    endfunction

    assign is_space  = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_sign   = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
    assign digit_val = rx_byte[3:0];
    assign ok1       = field_ok(fl1_reg, mag1_reg);
    assign ok2       = field_ok(fl2_reg, mag2_reg);
    assign hp        = (phase_reg == PH_LEAD) ? 2'd0 : hdr_reg;

    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        trail_next = trail_reg;
        mag1_next  = mag1_reg;
        mag2_next  = mag2_reg;
        fl1_next   = fl1_reg;
        fl2_next   = fl2_reg;
        if (accept)
        begin
            if (rx_byte == CH_LF)
            begin
                phase_next = PH_LEAD;
                hdr_next   = 2'd0;
                trail_next = 1'b0;
                mag1_next  = '0;
                mag2_next  = '0;
                fl1_next   = '0;
                fl2_next   = '0;
            end
            else if (phase_reg == PH_BAD)
            begin
                phase_next = PH_BAD;
            end
            else if (is_space)
            begin
                if (phase_reg != PH_LEAD)
                    trail_next = 1'b1;
            end
            else if (trail_reg)
            begin
                phase_next = PH_BAD;
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD, PH_HEADER:
                    begin
                        phase_next = PH_HEADER;
                        hdr_next   = hp;
                        if (hp == 2'd0 && rx_byte == CH_A)
                            hdr_next = 2'd1;
                        else if (hp == 2'd1 && rx_byte == CH_D)
                            hdr_next = 2'd2;
                        else if (hp == 2'd2 && rx_byte == CH_C)
                            hdr_next = 2'd3;
                        else if (hp == 2'd3 && rx_byte == CH_COMMA)
                            phase_next = PH_FIRST;
                        else
                            phase_next = PH_BAD;
                    end
                    PH_FIRST:
                    begin
                        if (rx_byte == CH_COMMA)
                            phase_next = ok1 ? PH_SECOND : PH_BAD;
                        else if (is_sign)
                        begin
                            if (fl1_reg.sign || fl1_reg.digit)
                                phase_next = PH_BAD;
                            else
                            begin
                                fl1_next.sign = 1'b1;
                                fl1_next.neg  = (rx_byte == CH_MINUS);
                            end
                        end
                        else if (is_digit)
                        begin
                            fl1_next.digit = 1'b1;
                            mag1_next      = mag_step(mag1_reg, digit_val);
                        end
                        else
                            phase_next = PH_BAD;
                    end
                    PH_SECOND:
                    begin
                        if (rx_byte == CH_COMMA)
                            phase_next = PH_BAD;
                        else if (is_sign)
                        begin
                            if (fl2_reg.sign || fl2_reg.digit)
                                phase_next = PH_BAD;
                            else
                            begin
                                fl2_next.sign = 1'b1;
                                fl2_next.neg  = (rx_byte == CH_MINUS);
                            end
                        end
                        else if (is_digit)
                        begin
                            fl2_next.digit = 1'b1;
                            mag2_next      = mag_step(mag2_reg, digit_val);
                        end
                        else
                            phase_next = PH_BAD;
                    end
                    default:
                        phase_next = PH_BAD;
                endcase
            end
        end
    end

    always_comb
    begin
        push = accept && (rx_byte == CH_LF) && (phase_reg == PH_SECOND) && ok1 && ok2;
        push_job.compass_level = level(fl1_reg, mag1_reg);
        push_job.cue_level     = level(fl2_reg, mag2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            hdr_reg   <= 2'd0;
            trail_reg <= 1'b0;
            mag1_reg  <= '0;
            mag2_reg  <= '0;
            fl1_reg   <= '0;
            fl2_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            trail_reg <= trail_next;
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag2_next;
            fl1_reg   <= fl1_next;
            fl2_reg   <= fl2_next;
        end
    end

endmodule

// ----- src/dialf_queue.sv -----
`timescale 1ns / 1ps

module dialf_queue
    import dialf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  line_job_t     push_job,
    input  logic          pop,
    output line_job_t     pop_job,
    output queue_status_t status
);

    line_job_t      slot_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign status.full  = (cnt_reg == QDEPTH[QAW:0]);
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/dialf_back.sv -----
`timescale 1ns / 1ps

module dialf_back
    import dialf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TURNS_W-1:0]   cfg_data,
    input  queue_status_t        q_status,
    input  line_job_t            q_job,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ANGLE_W-1:0]   compass_angle,
    output logic [ANGLE_W-1:0]   cue_angle,
    output logic                 compass_changed,
    output logic                 cue_changed
);

    localparam int PROD_W = LEVEL_W + TURNS_W;
    localparam int RECIP_SHIFT = 16;
    localparam logic [12:0] RECIP = 13'd5761;
    localparam logic [6:0]  DIV_Q = 7'd91;
    localparam logic [LEVEL_W:0] MOD_K = 13'd4095;

    logic [TURNS_W-1:0] compass_turns_reg, cue_turns_reg;

    logic               en;
    logic               s1_valid_reg, s2_valid_reg;
    logic [PROD_W-1:0]  s1_pc_reg, s1_pq_reg;
    logic [LEVEL_W-1:0] s2_rc_reg, s2_rq_reg;
    logic [ANGLE_W-1:0] s2_qc_reg, s2_qq_reg;
    logic [LEVEL_W-1:0] rc_w, rq_w;
    logic [ANGLE_W-1:0] qc_w, qq_w;
    logic [ANGLE_W-1:0] fc_w, fq_w;
    logic               cc_w, qcc_w;

    logic [ANGLE_W-1:0] last_c_reg, last_q_reg;
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_c_reg, out_q_reg;
    logic               out_cc_reg, out_qc_reg;

    function automatic logic [LEVEL_W-1:0] mod_sweep(logic [PROD_W-1:0] p);
        logic [LEVEL_W:0] s;
        logic [LEVEL_W:0] r;
        s = {1'b0, p[LEVEL_W-1:0]} + {{(2*LEVEL_W-PROD_W+1){1'b0}}, p[PROD_W-1:LEVEL_W]};
        r = (s >= MOD_K) ? s - MOD_K : s;
        return r[LEVEL_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] quot_est(logic [LEVEL_W-1:0] r);
        logic [LEVEL_W+12:0] m;
        m = {13'd0, r} * {12'd0, RECIP};
        return m[RECIP_SHIFT+ANGLE_W-1:RECIP_SHIFT];
    endfunction

    function automatic logic [ANGLE_W-1:0] quot_fix(logic [LEVEL_W-1:0] r,
                                                    logic [ANGLE_W-1:0] q);
        logic [LEVEL_W+2:0] rem;
        logic [LEVEL_W+2:0] prod;
        prod = {{(LEVEL_W+3-ANGLE_W){1'b0}}, q} * {{(LEVEL_W-4){1'b0}}, DIV_Q};
        rem  = {r, 3'b000} - prod;
        return (rem >= {{(LEVEL_W-4){1'b0}}, DIV_Q}) ? q + 1'b1 : q;
    endfunction

    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && !q_status.empty;

    assign rc_w = mod_sweep(s1_pc_reg);
    assign rq_w = mod_sweep(s1_pq_reg);
    assign qc_w = quot_est(rc_w);
    assign qq_w = quot_est(rq_w);

    assign fc_w  = quot_fix(s2_rc_reg, s2_qc_reg);
    assign fq_w  = quot_fix(s2_rq_reg, s2_qq_reg);
    assign cc_w  = (fc_w != last_c_reg);
    assign qcc_w = (fq_w != last_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compass_turns_reg <= TURNS_RESET;
            cue_turns_reg     <= TURNS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMPASS_TURNS: compass_turns_reg <= cfg_data;
                CFG_CUE_TURNS:     cue_turns_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pc_reg <= {{TURNS_W{1'b0}}, q_job.compass_level} * {{LEVEL_W{1'b0}}, compass_turns_reg};
            s1_pq_reg <= {{TURNS_W{1'b0}}, q_job.cue_level} * {{LEVEL_W{1'b0}}, cue_turns_reg};
            s2_rc_reg <= rc_w;
            s2_rq_reg <= rq_w;
            s2_qc_reg <= qc_w;
            s2_qq_reg <= qq_w;
            if (s2_valid_reg && (cc_w || qcc_w))
            begin
                out_c_reg  <= fc_w;
                out_q_reg  <= fq_w;
                out_cc_reg <= cc_w;
                out_qc_reg <= qcc_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_c_reg    <= '0;
            last_q_reg    <= '0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && (cc_w || qcc_w);
            if (s2_valid_reg && (cc_w || qcc_w))
            begin
                last_c_reg <= fc_w;
                last_q_reg <= fq_w;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign compass_angle   = out_c_reg;
    assign cue_angle       = out_q_reg;
    assign compass_changed = out_cc_reg;
    assign cue_changed     = out_qc_reg;

endmodule

// ----- src/adc_text_line_to_dial_frames_core.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake         | Payload
// ---------+-------------------+-------------------------------------------------
// input    | in_valid/in_stall | rx_byte
// output   | out_valid/out_stall | compass_angle, cue_angle, compass_changed, cue_changed
// config   | cfg_we            | cfg_index, cfg_data
//
// One byte per cycle is taken; in_stall rises only while the four-entry line queue is full.
// A changed frame of a valid line passes the line queue and a three-stage scaler
// (multiply by turns, reduce mod 4095 with reciprocal estimate, correct and compare).
// Scaler and output register advance together and hold while out_stall and out_valid are high.
// rst_n clears the parser, queue, scaler valids, stored frames and turns (to one).

module adc_text_line_to_dial_frames_core
    import dialf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TURNS_W-1:0]   cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ANGLE_W-1:0]   compass_angle,
    output logic [ANGLE_W-1:0]   cue_angle,
    output logic                 compass_changed,
    output logic                 cue_changed
);

    logic          accept;
    logic          push;
    line_job_t     push_job;
    line_job_t     pop_job;
    logic          pop;
    queue_status_t q_status;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    dialf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_job (push_job)
    );

    dialf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    dialf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_status        (q_status),
        .q_job           (pop_job),
        .q_pop           (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .compass_angle   (compass_angle),
        .cue_angle       (cue_angle),
        .compass_changed (compass_changed),
        .cue_changed     (cue_changed)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import dialf_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int FULL_TURN    = 360;
    localparam int RANDOM_BYTES = 1120;

    typedef struct packed {
        logic [ANGLE_W-1:0] ca;
        logic [ANGLE_W-1:0] qa;
        logic               cc;
        logic               qc;
    } dial_frame_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COMPASS_TURNS;
    logic [TURNS_W-1:0]   cfg_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ANGLE_W-1:0]   compass_angle;
    logic [ANGLE_W-1:0]   cue_angle;
    logic                 compass_changed;
    logic                 cue_changed;

    dial_frame_t frames_due[$];
    int mismatches    = 0;
    int cycles        = 0;
    int bytes_taken   = 0;
    bit gaps_on       = 1'b1;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int stall_left    = 0;
    int calm_left     = 0;

    phase_t              line_ph   = PH_LEAD;
    logic [1:0]          hdr_idx   = '0;
    logic                tail_ws   = 1'b0;
    longint unsigned     mag_a     = 0;
    longint unsigned     mag_b     = 0;
    field_flags_t        flg_a     = '0;
    field_flags_t        flg_b     = '0;
    logic [ANGLE_W-1:0]  prev_cmp  = '0;
    logic [ANGLE_W-1:0]  prev_cue  = '0;
    logic [TURNS_W-1:0]  turns_cmp = TURNS_RESET;
    logic [TURNS_W-1:0]  turns_cue = TURNS_RESET;

    adc_text_line_to_dial_frames_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .compass_angle   (compass_angle),
        .cue_angle       (cue_angle),
        .compass_changed (compass_changed),
        .cue_changed     (cue_changed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    function automatic bit is_ws(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit field_valid(input field_flags_t f, input longint unsigned m);
        if (!f.digit)
            return 1'b0;
        if (f.neg)
            return m <= MAG_LIMIT;
        return m <= MAG_LIMIT - 1;
    endfunction

    function automatic logic [ANGLE_W-1:0] frame_of(input field_flags_t f,
                                                    input longint unsigned m,
                                                    input logic [TURNS_W-1:0] turns);
        longint unsigned v;
        if (f.neg || m == 0)
            v = 0;
        else if (m > LEVEL_MAX)
            v = LEVEL_MAX;
        else
            v = m;
        return ANGLE_W'((v * FULL_TURN * turns) / LEVEL_MAX % FULL_TURN);
    endfunction

    task automatic clear_line();
        line_ph = PH_LEAD;
        hdr_idx = '0;
        tail_ws = 1'b0;
        mag_a   = 0;
        mag_b   = 0;
        flg_a   = '0;
        flg_b   = '0;
    endtask

    task automatic number_byte(input logic [BYTE_W-1:0] c, inout field_flags_t f,
                               inout longint unsigned m);
        longint unsigned nm;
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            if (f.sign || f.digit)
                line_ph = PH_BAD;
            else
            begin
                f.sign = 1'b1;
                if (c == CH_MINUS)
                    f.neg = 1'b1;
            end
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            f.digit = 1'b1;
            if (m <= MAG_LIMIT)
            begin
                nm = m * 10 + (c - CH_ZERO);
                m = (nm > MAG_LIMIT) ? MAG_OVER : nm;
            end
        end
        else
            line_ph = PH_BAD;
    endtask

    task automatic dial_model_byte(input logic [BYTE_W-1:0] c);
        logic [ANGLE_W-1:0] ca;
        logic [ANGLE_W-1:0] qa;
        dial_frame_t fr;
        if (c == CH_LF)
        begin
            if (line_ph == PH_SECOND && field_valid(flg_a, mag_a) && field_valid(flg_b, mag_b))
            begin
                ca = frame_of(flg_a, mag_a, turns_cmp);
                qa = frame_of(flg_b, mag_b, turns_cue);
                if (ca != prev_cmp || qa != prev_cue)
                begin
                    fr.ca = ca;
                    fr.qa = qa;
                    fr.cc = (ca != prev_cmp);
                    fr.qc = (qa != prev_cue);
                    frames_due.push_back(fr);
                    prev_cmp = ca;
                    prev_cue = qa;
                end
            end
            clear_line();
        end
        else if (line_ph != PH_BAD)
        begin
            if (is_ws(c))
            begin
                if (line_ph != PH_LEAD)
                    tail_ws = 1'b1;
            end
            else if (tail_ws)
                line_ph = PH_BAD;
            else
            begin
                case (line_ph)
                    PH_LEAD, PH_HEADER:
                    begin
                        if (line_ph == PH_LEAD)
                        begin
                            line_ph = PH_HEADER;
                            hdr_idx = '0;
                        end
                        if (hdr_idx == 2'd0 && c == CH_A)
                            hdr_idx = 2'd1;
                        else if (hdr_idx == 2'd1 && c == CH_D)
                            hdr_idx = 2'd2;
                        else if (hdr_idx == 2'd2 && c == CH_C)
                            hdr_idx = 2'd3;
                        else if (hdr_idx == 2'd3 && c == CH_COMMA)
                            line_ph = PH_FIRST;
                        else
                            line_ph = PH_BAD;
                    end
                    PH_FIRST:
                    begin
                        if (c == CH_COMMA)
                            line_ph = field_valid(flg_a, mag_a) ? PH_SECOND : PH_BAD;
                        else
                            number_byte(c, flg_a, mag_a);
                    end
                    PH_SECOND:
                    begin
                        if (c == CH_COMMA)
                            line_ph = PH_BAD;
                        else
                            number_byte(c, flg_b, mag_b);
                    end
                    default:
                        line_ph = PH_BAD;
                endcase
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int r;
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_taken++;
        dial_model_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_idle();
        int quiet;
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        quiet = 0;
        while (quiet < DRAIN_CYCLES)
        begin
            @(posedge clk);
            if (!out_stall)
                quiet++;
        end
    endtask

    task automatic write_turns(input logic [TURNS_W-1:0] a, input logic [TURNS_W-1:0] b);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COMPASS_TURNS;
        cfg_data  <= a;
        @(posedge clk);
        turns_cmp = a;
        @(negedge clk);
        cfg_index <= CFG_CUE_TURNS;
        cfg_data  <= b;
        @(posedge clk);
        turns_cue = b;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                out_stall <= 1'b0;
            else if (r < 85)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else if (r < 92)
            begin
                stall_left = $urandom_range(15, 60);
                out_stall <= 1'b1;
            end
            else
            begin
                calm_left = $urandom_range(40, 200);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_frames
        dial_frame_t got;
        dial_frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{compass_angle, cue_angle, compass_changed, cue_changed};
            if (frames_due.size() == 0)
                note_mismatch($sformatf("unexpected frame %0d/%0d changed %b/%b",
                                        got.ca, got.qa, got.cc, got.qc));
            else
            begin
                want = frames_due.pop_front();
                if (got !== want)
                    note_mismatch($sformatf(
                        "frame mismatch: exp %0d/%0d changed %b/%b, got %0d/%0d changed %b/%b",
                        want.ca, want.qa, want.cc, want.qc,
                        got.ca, got.qa, got.cc, got.qc));
            end
        end
    end

    function automatic logic [BYTE_W-1:0] ws_char();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic string random_number();
        int r;
        string s;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            s = $sformatf("%0d", $urandom_range(0, 4095));
            if ($urandom_range(0, 9) == 0)
                s = {"00", s};
            if ($urandom_range(0, 9) == 0)
                s = {"+", s};
        end
        else if (r < 62)
            s = $sformatf("-%0d", $urandom_range(0, 5000));
        else if (r < 72)
            s = $sformatf("%0d", $urandom & 32'h7FFF_FFFF);
        else if (r < 82)
        begin
            case ($urandom_range(0, 7))
                0:       s = "2147483647";
                1:       s = "2147483648";
                2:       s = "-2147483648";
                3:       s = "-2147483649";
                4:       s = "-0";
                5:       s = "+0";
                6:       s = "4095";
                default: s = "4096";
            endcase
        end
        else if (r < 90)
        begin
            s = "";
            repeat ($urandom_range(10, 16))
                s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       s = "";
                1:       s = "+";
                2:       s = "-";
                3:       s = "+-3";
                default: s = "12-3";
            endcase
        end
        return s;
    endfunction

    task automatic random_line();
        logic [BYTE_W-1:0] bq[$];
        int r;
        int pos;
        string s;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            repeat ($urandom_range(1, 16))
                bq.push_back(BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                bq.push_back(CH_LF);
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    bq.push_back(ws_char());
            s = $sformatf("ADC,%s,%s", random_number(), random_number());
            for (int i = 0; i < s.len(); i++)
                bq.push_back(s[i]);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    bq.push_back(ws_char());
            if (r >= 86)
            begin
                pos = $urandom_range(0, bq.size() - 1);
                case ($urandom_range(0, 2))
                    0:       bq[pos] = BYTE_W'($urandom_range(0, 255));
                    1:       bq.insert(pos, ws_char());
                    default: bq.delete(pos);
                endcase
            end
            bq.push_back(CH_LF);
        end
        gaps_on = ($urandom_range(0, 3) != 0);
        foreach (bq[i])
            send_byte(bq[i]);
    endtask

    function automatic logic [TURNS_W-1:0] random_turns();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return TURNS_W'($urandom_range(1, 50));
        if (r < 85)
            return $urandom_range(0, 1) ? 6'd50 : 6'd1;
        return $urandom_range(0, 1) ? 6'd63 : 6'd0;
    endfunction

    task automatic test_line_forms();
        send_text("ADC,4095,2048\n");
        send_text("ADC,4095,2048\n");
        send_text("ADC,4095,100\n");
        send_text(" \t\013\014ADC,-5,+4095 \015\n");
        send_text("\n");
        send_text(" \t \n");
        send_text("ADC, 1,2\n");
        send_text("adc,1,2\n");
        send_text("ADC,1\n");
        send_text("ADC,1,2,3\n");
        send_text("ADC,,1\n");
        send_text("ADC,1,\n");
        send_text("ADC,+-1,2\n");
        send_text("ADC,1-,2\n");
        send_text("ADC,7,8 9\n");
        send_text("ADCX,1,2\n");
        send_text("ADC,1\377,2\n");
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(CH_LF);
    endtask

    task automatic test_field_limits();
        send_text("ADC,2147483647,-2147483648\n");
        send_text("ADC,2147483648,1\n");
        send_text("ADC,1,-2147483649\n");
        send_text("ADC,00000000000000000004095,0001\n");
        send_text("ADC,99999999999999999999,1\n");
        send_text("ADC,0,-0\n");
        send_text("ADC,+4096,4094\n");
    endtask

    task automatic test_turn_settings();
        logic [TURNS_W-1:0] cmp_set[5] = '{6'd50, 6'd0, 6'd63, 6'd1, 6'd37};
        logic [TURNS_W-1:0] cue_set[5] = '{6'd50, 6'd0, 6'd1, 6'd63, 6'd1};
        for (int i = 0; i < 5; i++)
        begin
            wait_idle();
            write_turns(cmp_set[i], cue_set[i]);
            send_text("ADC,4095,4095\n");
            send_text("ADC,2048,1\n");
            send_text("ADC,1,4094\n");
            send_text("ADC,3000,2047\n");
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++)
            send_text($sformatf("ADC,%0d,%0d\n", i * 200 + 5, 4000 - i * 150));
        @(negedge clk);
        in_valid <= 1'b0;
        while (hold_req || hold_left > 0)
            @(posedge clk);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int next_cfg;
        start_bytes  = bytes_taken;
        next_cfg     = bytes_taken + 300;
        while (bytes_taken - start_bytes < RANDOM_BYTES)
        begin
            if (bytes_taken >= next_cfg)
            begin
                wait_idle();
                write_turns(random_turns(), random_turns());
                next_cfg = bytes_taken + $urandom_range(200, 400);
            end
            random_line();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        clear_line();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_line_forms();
        test_field_limits();
        test_turn_settings();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- adc_text_line_to_dial_frames_core.f -----
src/dialf_pkg.sv
src/dialf_front.sv
src/dialf_queue.sv
src/dialf_back.sv
src/adc_text_line_to_dial_frames_core.sv
bench/tb.sv
